// File: src/tpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tpe_pkg;

  // Primitive selector codes carried on the input tuser
  localparam logic [3:0] ACT_NULL     = 4'd0;
  localparam logic [3:0] ACT_BOOL     = 4'd1;
  localparam logic [3:0] ACT_UNSIGNED = 4'd2;
  localparam logic [3:0] ACT_ENUM     = 4'd3;
  localparam logic [3:0] ACT_SIGNED   = 4'd4;
  localparam logic [3:0] ACT_REAL     = 4'd5;
  localparam logic [3:0] ACT_DOUBLE   = 4'd6;
  localparam logic [3:0] ACT_DATE     = 4'd7;
  localparam logic [3:0] ACT_TIME     = 4'd8;
  localparam logic [3:0] ACT_OBJID    = 4'd9;
  localparam logic [3:0] ACT_CTX_UNS  = 4'd10;
  localparam logic [3:0] ACT_CTX_ENUM = 4'd11;
  localparam logic [3:0] ACT_CTX_SGN  = 4'd12;
  localparam logic [3:0] ACT_CTX_BOOL = 4'd13;
  localparam logic [3:0] ACT_OPEN     = 4'd14;
  localparam logic [3:0] ACT_CLOSE    = 4'd15;

  // Header constants
  localparam logic [7:0] CLASS_CONTEXT = 8'h08;
  localparam logic [7:0] TAG_EXTENDED  = 8'hF0;
  localparam logic [7:0] TAG_REJECTED  = 8'd255;
  localparam logic [7:0] TAG_EXT_MIN   = 8'd15;
  localparam logic [3:0] LVT_EXT_LEN   = 4'd5;
  localparam logic [3:0] LVT_OPEN      = 4'd6;
  localparam logic [3:0] LVT_CLOSE     = 4'd7;

  // Application tag numbers
  localparam logic [7:0] TAG_NULL     = 8'd0;
  localparam logic [7:0] TAG_BOOL     = 8'd1;
  localparam logic [7:0] TAG_UNSIGNED = 8'd2;
  localparam logic [7:0] TAG_SIGNED   = 8'd3;
  localparam logic [7:0] TAG_REAL     = 8'd4;
  localparam logic [7:0] TAG_DOUBLE   = 8'd5;
  localparam logic [7:0] TAG_ENUM     = 8'd9;
  localparam logic [7:0] TAG_DATE     = 8'd10;
  localparam logic [7:0] TAG_TIME     = 8'd11;
  localparam logic [7:0] TAG_OBJID    = 8'd12;

  // Value range constants
  localparam logic [30:0] REAL_INF   = 31'h7F80_0000;
  localparam logic [62:0] DOUBLE_INF = 63'h7FF0_0000_0000_0000;
  localparam logic [15:0] YEAR_BASE  = 16'd1900;
  localparam logic [15:0] YEAR_TOP   = 16'd2154;
  localparam logic [7:0]  FIELD_ANY  = 8'd255;

  // Decoded request after the check stage
  typedef struct packed {
    logic [7:0]  tag;
    logic        ctx;
    logic        is_len;
    logic [3:0]  lvt;
    logic [3:0]  blen;
    logic [63:0] body;   // contents left-aligned, first octet in the top bits
    logic        ok;
    logic [7:0]  room;
  } chk_t;

  // Assembled encoding after the build stage
  typedef struct packed {
    logic [79:0] octets; // first octet in the top bits
    logic [3:0]  total;
    logic        err;
  } bld_t;

endpackage
`default_nettype wire

// File: src/tagged_primitive_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Tagged primitive encoder: one request on the slave stream carries a primitive
// selector in s_tuser and its value fields in s_tdata; the block returns the
// tagged encoding on the master stream, one octet per beat, most significant
// first, with m_tlast on the final octet. A rejected request (bad field, NaN,
// context tag 255 or too little room) gives a single beat with m_tuser set,
// zero data and m_tlast set. The first octet comes out after the request passes
// the check, build and serializer registers in turn; a request then gives one
// beat per octet of its encoding, 1 to 10, from the output serializer, which
// sends one octet a cycle while m_tready is high. Check and build stages hold up
// to two more requests behind it. The year code register is written through
// cfg_wr_en / cfg_wr_data and resets to 65535.
module tagged_primitive_encoder
  import tpe_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic [15:0]  cfg_wr_data,  // year_unspecified_code
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // s_tdata, from bit 0: context_tag[7:0], low_word[39:8], high_word[71:40],
  // wide_field[87:72], octet_1[95:88], octet_2[103:96], octet_3[111:104],
  // octet_4[119:112], room[127:120]
  input  wire logic [127:0] s_tdata,
  input  wire logic [3:0]   s_tuser,      // action[3:0]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [7:0]        m_tdata,      // out_octet[7:0]
  output logic              m_tlast,      // last_octet
  output logic              m_tuser       // error_flag
);

  logic [15:0] year_code;
  logic        chk_valid, chk_ready;
  chk_t        chk_data;
  logic        bld_valid, bld_ready;
  bld_t        bld_data;

  // Hold the year code register
  always_ff @(posedge clk) begin
    if (rst) begin
      year_code <= 16'hFFFF;
    end else if (cfg_wr_en) begin
      year_code <= cfg_wr_data;
    end
  end

  tpe_check u_check (
    .clk       (clk),
    .rst       (rst),
    .year_code (year_code),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .action    (s_tuser),
    .fields    (s_tdata),
    .out_valid (chk_valid),
    .out_ready (chk_ready),
    .out_data  (chk_data)
  );

  tpe_build u_build (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chk_valid),
    .in_ready  (chk_ready),
    .in_data   (chk_data),
    .out_valid (bld_valid),
    .out_ready (bld_ready),
    .out_data  (bld_data)
  );

  tpe_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (bld_valid),
    .in_ready  (bld_ready),
    .in_data   (bld_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_octet (m_tdata),
    .out_last  (m_tlast),
    .out_err   (m_tuser)
  );

  // An error beat is the only beat of its request and carries zero data
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
    else $error("error beat not final or not zero");

  // A stalled check stage keeps its request
  a_chk_hold: assert property (@(posedge clk) disable iff (rst)
    chk_valid && !chk_ready |=> chk_valid && $stable(chk_data))
    else $error("check stage dropped a stalled request");

  // A stalled build stage keeps its encoding
  a_bld_hold: assert property (@(posedge clk) disable iff (rst)
    bld_valid && !bld_ready |=> bld_valid && $stable(bld_data))
    else $error("build stage dropped a stalled encoding");

  // Nothing leaves right after reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule
`default_nettype wire

// File: src/tpe_check.sv
`timescale 1ns / 1ps
`default_nettype none
module tpe_check
  import tpe_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [15:0]  year_code,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [3:0]   action,
  input  wire logic [127:0] fields,
  output logic              out_valid,
  input  wire logic         out_ready,
  output chk_t              out_data
);

  logic [7:0]  ctag;
  logic [31:0] lo;
  logic [31:0] hi;
  logic [15:0] wide;
  logic [7:0]  o1, o2, o3, o4, room;
  logic [31:0] ival;
  logic        sgn;
  logic [3:0]  nmin;
  logic [15:0] ydiff;
  logic [7:0]  year_oct;
  logic        year_ok;
  chk_t        data_next;

  assign ctag = fields[7:0];
  assign lo   = fields[39:8];
  assign hi   = fields[71:40];
  assign wide = fields[87:72];
  assign o1   = fields[95:88];
  assign o2   = fields[103:96];
  assign o3   = fields[111:104];
  assign o4   = fields[119:112];
  assign room = fields[127:120];

  function automatic logic field_ok(input logic [7:0] v, input logic [7:0] lo_b,
                                    input logic [7:0] hi_b);
    field_ok = (v >= lo_b && v <= hi_b) || v == FIELD_ANY;
  endfunction

  // Fewest octets that keep the value, sign-extended when signed
  function automatic logic [3:0] min_octets(input logic [31:0] v, input logic s);
    logic [7:0] e3, e2, e1;
    logic [3:0] n;
    e3 = {8{s & v[23]}};
    e2 = {8{s & v[15]}};
    e1 = {8{s & v[7]}};
    if (v[31:24] != e3) n = 4'd4;
    else if (v[23:16] != e2) n = 4'd3;
    else if (v[15:8] != e1) n = 4'd2;
    else n = 4'd1;
    min_octets = n;
  endfunction

  // Integer value and its octet count
  assign sgn  = (action == ACT_SIGNED) || (action == ACT_CTX_SGN);
  assign ival = (action == ACT_CTX_BOOL) ? {31'd0, lo != 32'd0} : lo;
  assign nmin = min_octets(ival, sgn);

  // Year mapping with the unspecified code checked first
  assign ydiff = wide - YEAR_BASE;
  always_comb begin
    year_ok  = 1'b1;
    year_oct = ydiff[7:0];
    if (wide == year_code) begin
      year_oct = FIELD_ANY;
    end else if (wide < YEAR_BASE || wide > YEAR_TOP) begin
      year_ok = 1'b0;
    end
  end

  // Decode the request
  always_comb begin
    data_next.tag    = TAG_NULL;
    data_next.ctx    = 1'b0;
    data_next.is_len = 1'b1;
    data_next.lvt    = 4'd0;
    data_next.blen   = 4'd0;
    data_next.body   = 64'd0;
    data_next.ok     = 1'b1;
    data_next.room   = room;
    case (action)
      ACT_NULL: begin
        data_next.tag = TAG_NULL;
      end
      ACT_BOOL: begin
        data_next.tag    = TAG_BOOL;
        data_next.is_len = 1'b0;
        data_next.lvt    = {3'd0, lo != 32'd0};
      end
      ACT_UNSIGNED, ACT_ENUM, ACT_SIGNED, ACT_CTX_UNS, ACT_CTX_ENUM, ACT_CTX_SGN,
      ACT_CTX_BOOL: begin
        data_next.ctx  = action >= ACT_CTX_UNS;
        if (action >= ACT_CTX_UNS) data_next.tag = ctag;
        else if (action == ACT_UNSIGNED) data_next.tag = TAG_UNSIGNED;
        else if (action == ACT_ENUM) data_next.tag = TAG_ENUM;
        else data_next.tag = TAG_SIGNED;
        data_next.blen = nmin;
        data_next.lvt  = nmin;
        case (nmin)
          4'd1:    data_next.body = {ival[7:0], 56'd0};
          4'd2:    data_next.body = {ival[15:0], 48'd0};
          4'd3:    data_next.body = {ival[23:0], 40'd0};
          default: data_next.body = {ival, 32'd0};
        endcase
      end
      ACT_REAL: begin
        data_next.tag  = TAG_REAL;
        data_next.ok   = lo[30:0] <= REAL_INF;
        data_next.blen = 4'd4;
        data_next.lvt  = 4'd4;
        data_next.body = {lo, 32'd0};
      end
      ACT_DOUBLE: begin
        data_next.tag  = TAG_DOUBLE;
        data_next.ok   = {hi[30:0], lo} <= DOUBLE_INF;
        data_next.blen = 4'd8;
        data_next.lvt  = 4'd8;
        data_next.body = {hi, lo};
      end
      ACT_DATE: begin
        data_next.tag  = TAG_DATE;
        data_next.ok   = year_ok && field_ok(o1, 8'd1, 8'd14) &&
                         field_ok(o2, 8'd1, 8'd34) && field_ok(o3, 8'd1, 8'd7);
        data_next.blen = 4'd4;
        data_next.lvt  = 4'd4;
        data_next.body = {year_oct, o1, o2, o3, 32'd0};
      end
      ACT_TIME: begin
        data_next.tag  = TAG_TIME;
        data_next.ok   = field_ok(o1, 8'd0, 8'd23) && field_ok(o2, 8'd0, 8'd59) &&
                         field_ok(o3, 8'd0, 8'd59) && field_ok(o4, 8'd0, 8'd99);
        data_next.blen = 4'd4;
        data_next.lvt  = 4'd4;
        data_next.body = {o1, o2, o3, o4, 32'd0};
      end
      ACT_OBJID: begin
        data_next.tag  = TAG_OBJID;
        data_next.ok   = (wide[15:10] == 6'd0) && (lo[31:22] == 10'd0);
        data_next.blen = 4'd4;
        data_next.lvt  = 4'd4;
        data_next.body = {wide[9:0], lo[21:0], 32'd0};
      end
      ACT_OPEN: begin
        data_next.tag    = ctag;
        data_next.ctx    = 1'b1;
        data_next.is_len = 1'b0;
        data_next.lvt    = LVT_OPEN;
      end
      default: begin
        data_next.tag    = ctag;
        data_next.ctx    = 1'b1;
        data_next.is_len = 1'b0;
        data_next.lvt    = LVT_CLOSE;
      end
    endcase
  end

  // Advance when the stage is empty or its request moves on
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// File: src/tpe_build.sv
`timescale 1ns / 1ps
`default_nettype none
module tpe_build
  import tpe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  chk_t      in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output bld_t      out_data
);

  logic        ext_tag;
  logic        ext_len;
  logic [7:0]  h0;
  logic [23:0] hdr;
  logic [1:0]  hn;
  logic [3:0]  total;
  logic [87:0] full;
  bld_t        data_next;

  assign ext_tag = in_data.tag >= TAG_EXT_MIN;
  assign ext_len = in_data.is_len && (in_data.lvt >= LVT_EXT_LEN);

  // Initial tag octet
  always_comb begin
    h0 = in_data.ctx ? CLASS_CONTEXT : 8'd0;
    if (ext_tag) h0 = h0 | TAG_EXTENDED;
    else h0 = h0 | {in_data.tag[3:0], 4'd0};
    if (ext_len) h0 = h0 | {4'd0, LVT_EXT_LEN};
    else h0 = h0 | {5'd0, in_data.lvt[2:0]};
  end

  // Header octets left-aligned, then contents right behind them
  always_comb begin
    if (ext_tag && ext_len) hdr = {h0, in_data.tag, 4'd0, in_data.lvt};
    else if (ext_tag) hdr = {h0, in_data.tag, 8'd0};
    else if (ext_len) hdr = {h0, 4'd0, in_data.lvt, 8'd0};
    else hdr = {h0, 16'd0};
  end

  assign hn    = 2'd1 + {1'b0, ext_tag} + {1'b0, ext_len};
  assign total = {2'd0, hn} + in_data.blen;
  assign full  = {hdr, 64'd0} | ({24'd0, in_data.body} << (8 * (3 - hn)));

  assign data_next.octets = full[87:8];
  assign data_next.total  = total;
  assign data_next.err    = !in_data.ok || (in_data.tag == TAG_REJECTED) ||
                            ({4'd0, total} > in_data.room);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= data_next;
    end
  end

endmodule
`default_nettype wire

// File: src/tpe_serial.sv
`timescale 1ns / 1ps
`default_nettype none
module tpe_serial
  import tpe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  bld_t       in_data,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0] out_octet,
  output logic       out_last,
  output logic       out_err
);

  logic [79:0] octets;
  logic [3:0]  remain;
  logic        err;

  assign out_octet = err ? 8'd0 : octets[79:72];
  assign out_last  = err || (remain == 4'd1);
  assign out_err   = err;

  // Take the next encoding once the final octet of this one is taken
  assign in_ready = !out_valid || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Load a new encoding or shift out one octet
  always_ff @(posedge clk) begin
    if (in_ready) begin
      octets <= in_data.octets;
      remain <= in_data.total;
      err    <= in_data.err;
    end else if (out_ready) begin
      octets <= {octets[71:0], 8'd0};
      remain <= remain - 4'd1;
    end
  end

endmodule
`default_nettype wire
